// File: src/segment_path_interpolator_core_assert.svh
// Assertion macros for the segment path interpolator.
// Used by the top level only; no other dependencies.
`ifndef SEGMENT_PATH_INTERPOLATOR_CORE_ASSERT_SVH
`define SEGMENT_PATH_INTERPOLATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// check that holds outside reset
`define SPI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check that holds during reset as well
`define SPI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SPI_ASSERT(lbl, prop, msg)
`define SPI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: src/spi_pkg.sv
// Shared types, constants and command codes of the segment path interpolator.
// No dependencies.
package spi_pkg;

  localparam int unsigned SAMPLE_MAX_INT = 63;
  localparam logic [5:0]  SAMPLE_MAX     = 6'(SAMPLE_MAX_INT);
  localparam logic [31:0] SPACING_RESET  = 32'd16384;
  localparam logic [14:0] QUAT_ONE       = 15'd16384;

  // last count value of each iterative phase
  localparam logic [5:0] SQRT_LAST = 6'd33;
  localparam logic [5:0] DIVM_LAST = 6'd32;
  localparam logic [5:0] YDIV_LAST = 6'd26;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic               include_start;
  } seg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_z;
    logic        [14:0] quat_w;
    logic               clipped;
    logic               last;
  } pose_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ0,
    OP_SQ1,
    OP_SQ2,
    OP_SQRT_LOAD,
    OP_SQRT_STEP,
    OP_SEARCH_INIT,
    OP_SEARCH,
    OP_DIVM_INIT,
    OP_DIVM_STEP,
    OP_YDIV_INIT,
    OP_YDIV_STEP,
    OP_YSAVE,
    OP_EMIT_INIT,
    OP_EMIT_STEP
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ0,
    ST_SQ1,
    ST_SXY_LD,
    ST_SXY_RUN,
    ST_SQ2,
    ST_SUM_LD,
    ST_SUM_RUN,
    ST_SRCH_LD,
    ST_SRCH,
    ST_DIVM_LD,
    ST_DIVM_RUN,
    ST_YDIV_LD,
    ST_YDIV_RUN,
    ST_YSQ_LD,
    ST_YSQ_RUN,
    ST_YSAVE,
    ST_EMIT_LD,
    ST_SKIP,
    ST_EMIT
  } st_e;

  typedef struct packed {
    op_e  op;
    logic side;    // 0: quat_w, 1: quat_z
    logic sq_src;  // 0: square accumulator, 1: yaw quotient
  } cmd_t;

  typedef struct packed {
    logic search_done;
    logic xy_zero;
    logic last;
  } status_t;

endpackage

// File: src/spi_sqrt.sv
// Bit-serial integer square root, two radicand bits per step, 34 steps.
// Depends on nothing; driven by the datapath.
module spi_sqrt (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic        step_i,
  input  logic [67:0] rad_i,
  output logic [33:0] root_o,
  output logic [35:0] rem_o
);

  logic [67:0] x_q, x_d;
  logic [35:0] rem_q, rem_d;
  logic [33:0] root_q, root_d;
  logic [37:0] rem_sh, trial;
  logic        ge;

  // one restoring root digit
  always_comb begin
    rem_sh = {rem_q, x_q[67:66]};
    trial  = {2'b00, root_q, 2'b01};
    ge     = rem_sh >= trial;
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (load_i) begin
      x_d    = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (step_i) begin
      x_d    = {x_q[65:0], 2'b00};
      rem_d  = ge ? 36'(rem_sh - trial) : rem_sh[35:0];
      root_d = {root_q[32:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
  assign rem_o  = rem_q;

endmodule

// File: src/spi_ctrl.sv
// Sequencer of the segment path interpolator: phase order and step counts.
// Depends on spi_pkg.
module spi_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             include_start_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  spi_pkg::status_t status_i,
  output spi_pkg::cmd_t    cmd_o
);

  spi_pkg::st_e state_q, state_d;
  logic [5:0]   cnt_q, cnt_d;
  logic         side_q, side_d;

  // state, step counter, yaw side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spi_pkg::ST_IDLE;
      cnt_q   <= '0;
      side_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      side_q  <= side_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    side_d      = side_q;
    cmd_o.op    = spi_pkg::OP_NONE;
    cmd_o.side  = side_q;
    cmd_o.sq_src = 1'b0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      spi_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = spi_pkg::OP_LOAD;
          state_d  = spi_pkg::ST_SQ0;
        end
      end
      spi_pkg::ST_SQ0: begin
        cmd_o.op = spi_pkg::OP_SQ0;
        state_d  = spi_pkg::ST_SQ1;
      end
      spi_pkg::ST_SQ1: begin
        cmd_o.op = spi_pkg::OP_SQ1;
        state_d  = spi_pkg::ST_SXY_LD;
      end
      spi_pkg::ST_SXY_LD: begin
        cmd_o.op = spi_pkg::OP_SQRT_LOAD;
        cnt_d    = '0;
        state_d  = spi_pkg::ST_SXY_RUN;
      end
      spi_pkg::ST_SXY_RUN: begin
        cmd_o.op = spi_pkg::OP_SQRT_STEP;
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == spi_pkg::SQRT_LAST) state_d = spi_pkg::ST_SQ2;
      end
      spi_pkg::ST_SQ2: begin
        cmd_o.op = spi_pkg::OP_SQ2;
        state_d  = spi_pkg::ST_SUM_LD;
      end
      spi_pkg::ST_SUM_LD: begin
        cmd_o.op = spi_pkg::OP_SQRT_LOAD;
        cnt_d    = '0;
        state_d  = spi_pkg::ST_SUM_RUN;
      end
      spi_pkg::ST_SUM_RUN: begin
        cmd_o.op = spi_pkg::OP_SQRT_STEP;
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == spi_pkg::SQRT_LAST) state_d = spi_pkg::ST_SRCH_LD;
      end
      spi_pkg::ST_SRCH_LD: begin
        cmd_o.op = spi_pkg::OP_SEARCH_INIT;
        state_d  = spi_pkg::ST_SRCH;
      end
      spi_pkg::ST_SRCH: begin
        cmd_o.op = spi_pkg::OP_SEARCH;
        if (status_i.search_done) state_d = spi_pkg::ST_DIVM_LD;
      end
      spi_pkg::ST_DIVM_LD: begin
        cmd_o.op = spi_pkg::OP_DIVM_INIT;
        cnt_d    = '0;
        state_d  = spi_pkg::ST_DIVM_RUN;
      end
      spi_pkg::ST_DIVM_RUN: begin
        cmd_o.op = spi_pkg::OP_DIVM_STEP;
        cnt_d    = cnt_q + 6'd1;
        side_d   = 1'b0;
        if (cnt_q == spi_pkg::DIVM_LAST) begin
          state_d = status_i.xy_zero ? spi_pkg::ST_EMIT_LD : spi_pkg::ST_YDIV_LD;
        end
      end
      spi_pkg::ST_YDIV_LD: begin
        cmd_o.op = spi_pkg::OP_YDIV_INIT;
        cnt_d    = '0;
        state_d  = spi_pkg::ST_YDIV_RUN;
      end
      spi_pkg::ST_YDIV_RUN: begin
        cmd_o.op = spi_pkg::OP_YDIV_STEP;
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == spi_pkg::YDIV_LAST) state_d = spi_pkg::ST_YSQ_LD;
      end
      spi_pkg::ST_YSQ_LD: begin
        cmd_o.op     = spi_pkg::OP_SQRT_LOAD;
        cmd_o.sq_src = 1'b1;
        cnt_d        = '0;
        state_d      = spi_pkg::ST_YSQ_RUN;
      end
      spi_pkg::ST_YSQ_RUN: begin
        cmd_o.op = spi_pkg::OP_SQRT_STEP;
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == spi_pkg::SQRT_LAST) state_d = spi_pkg::ST_YSAVE;
      end
      spi_pkg::ST_YSAVE: begin
        cmd_o.op = spi_pkg::OP_YSAVE;
        side_d   = 1'b1;
        state_d  = side_q ? spi_pkg::ST_EMIT_LD : spi_pkg::ST_YDIV_LD;
      end
      spi_pkg::ST_EMIT_LD: begin
        cmd_o.op = spi_pkg::OP_EMIT_INIT;
        state_d  = include_start_i ? spi_pkg::ST_EMIT : spi_pkg::ST_SKIP;
      end
      spi_pkg::ST_SKIP: begin
        // step from sample zero to sample one
        cmd_o.op = spi_pkg::OP_EMIT_STEP;
        state_d  = spi_pkg::ST_EMIT;
      end
      spi_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.last) state_d = spi_pkg::ST_IDLE;
          else               cmd_o.op = spi_pkg::OP_EMIT_STEP;
        end
      end
      default: state_d = spi_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: src/spi_dp.sv
// Datapath of the segment path interpolator: squares, root, count search,
// per-axis step division, yaw quotients and sample stepping. Uses spi_pkg, spi_sqrt.
module spi_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [31:0]      cfg_wdata_i,
  input  spi_pkg::seg_t    in_i,
  input  spi_pkg::cmd_t    cmd_i,
  output spi_pkg::status_t status_o,
  output logic             include_start_o,
  output spi_pkg::pose_t   out_o
);

  logic [31:0]        spacing_q;
  logic signed [31:0] s_q [3];
  logic [32:0]        m_q [3];
  logic [2:0]         neg_q;
  logic               inc_q;
  logic [65:0]        acc_q;
  logic [33:0]        r_q;
  logic [34:0]        rc_q;
  logic [37:0]        t_q;
  logic [5:0]         k_q, n_q, i_q;
  logic               clip_q;
  logic [32:0]        sr_q [3];
  logic [5:0]         rm_q [3];
  logic [28:0]        yq_q;
  logic [33:0]        yrem_q;
  logic [14:0]        qw_q;
  logic signed [15:0] qz_q;
  logic [32:0]        qo_q [3];
  logic [7:0]         rr_q [3];

  // spacing register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) spacing_q <= spi_pkg::SPACING_RESET;
    else if (cfg_we_i) spacing_q <= cfg_wdata_i;
  end

  // shared square root
  logic [67:0] rad;
  logic [33:0] root;
  logic [35:0] rem;
  assign rad = cmd_i.sq_src ? {39'd0, yq_q} : {2'b00, acc_q};

  spi_sqrt u_sqrt (
    .clk_i  (clk_i),
    .load_i (cmd_i.op == spi_pkg::OP_SQRT_LOAD),
    .step_i (cmd_i.op == spi_pkg::OP_SQRT_STEP),
    .rad_i  (rad),
    .root_o (root),
    .rem_o  (rem)
  );

  // segment deltas
  logic signed [32:0] de [3];
  logic signed [31:0] st_in [3];
  logic signed [31:0] en_in [3];
  assign st_in[0] = in_i.start_x;
  assign st_in[1] = in_i.start_y;
  assign st_in[2] = in_i.start_z;
  assign en_in[0] = in_i.end_x;
  assign en_in[1] = in_i.end_y;
  assign en_in[2] = in_i.end_z;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      de[c] = {en_in[c][31], en_in[c]} - {st_in[c][31], st_in[c]};
    end
  end

  // squarer
  logic [32:0] mul_a;
  logic [65:0] prod;
  always_comb begin
    case (cmd_i.op)
      spi_pkg::OP_SQ1: mul_a = m_q[1];
      spi_pkg::OP_SQ2: mul_a = m_q[2];
      default:         mul_a = m_q[0];
    endcase
  end
  assign prod = 66'(mul_a) * 66'(mul_a);

  // count search compare
  logic search_hit, search_done;
  assign search_hit  = {1'b0, t_q} >= {4'd0, rc_q};
  assign search_done = search_hit || (k_q == spi_pkg::SAMPLE_MAX);

  // yaw numerator r +/- dx
  logic [34:0] ynum, r2;
  logic        ysub;
  assign ysub = cmd_i.side ^ neg_q[0];
  assign ynum = ysub ? 35'({1'b0, r_q} - {2'b00, m_q[0]})
                     : 35'({1'b0, r_q} + {2'b00, m_q[0]});
  assign r2   = {r_q, 1'b0};
  logic [34:0] ysh;
  logic        yge;
  assign ysh = {yrem_q, 1'b0};
  assign yge = ysh >= {1'b0, r_q};

  // rounded root of the yaw quotient, clamped to one
  logic [34:0] rnd;
  logic [14:0] qmag;
  assign rnd  = {1'b0, root} + 35'({34'd0, {1'b0, rem} > {3'd0, root}});
  assign qmag = (rnd > 35'(spi_pkg::QUAT_ONE)) ? spi_pkg::QUAT_ONE : rnd[14:0];

  // per-axis step lanes
  logic [6:0] dsh [3];
  logic       dge [3];
  logic [7:0] esum [3];
  logic       ecor [3];
  logic [7:0] n2;
  assign n2 = {1'b0, n_q, 1'b0};
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dsh[c]  = {rm_q[c], sr_q[c][32]};
      dge[c]  = dsh[c] >= {1'b0, n_q};
      esum[c] = rr_q[c] + {1'b0, rm_q[c], 1'b0};
      ecor[c] = esum[c] >= n2;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      spi_pkg::OP_LOAD: begin
        for (int c = 0; c < 3; c++) begin
          s_q[c]   <= st_in[c];
          neg_q[c] <= de[c][32];
          m_q[c]   <= de[c][32] ? 33'(-de[c]) : 33'(de[c]);
        end
        inc_q <= in_i.include_start;
        qw_q  <= spi_pkg::QUAT_ONE;
        qz_q  <= '0;
      end
      spi_pkg::OP_SQ0: acc_q <= prod;
      spi_pkg::OP_SQ1: acc_q <= acc_q + prod;
      spi_pkg::OP_SQ2: begin
        acc_q <= acc_q + prod;
        r_q   <= root;
      end
      spi_pkg::OP_SEARCH_INIT: begin
        rc_q <= {1'b0, root} + 35'({34'd0, rem != 36'd0});
        t_q  <= {6'd0, spacing_q};
        k_q  <= 6'd1;
      end
      spi_pkg::OP_SEARCH: begin
        if (search_done) begin
          n_q    <= k_q;
          clip_q <= !search_hit;
        end else begin
          t_q <= t_q + {6'd0, spacing_q};
          k_q <= k_q + 6'd1;
        end
      end
      spi_pkg::OP_DIVM_INIT: begin
        for (int c = 0; c < 3; c++) begin
          sr_q[c] <= m_q[c];
          rm_q[c] <= '0;
        end
      end
      spi_pkg::OP_DIVM_STEP: begin
        for (int c = 0; c < 3; c++) begin
          rm_q[c] <= dge[c] ? 6'(dsh[c] - {1'b0, n_q}) : dsh[c][5:0];
          sr_q[c] <= {sr_q[c][31:0], dge[c]};
        end
      end
      spi_pkg::OP_YDIV_INIT: begin
        // integer part of (r +/- dx) / r is 0, 1 or 2
        if (ynum >= r2) begin
          yq_q   <= 29'd2;
          yrem_q <= 34'(ynum - r2);
        end else if (ynum >= {1'b0, r_q}) begin
          yq_q   <= 29'd1;
          yrem_q <= 34'(ynum - {1'b0, r_q});
        end else begin
          yq_q   <= 29'd0;
          yrem_q <= ynum[33:0];
        end
      end
      spi_pkg::OP_YDIV_STEP: begin
        yrem_q <= yge ? 34'(ysh - {1'b0, r_q}) : ysh[33:0];
        yq_q   <= {yq_q[27:0], yge};
      end
      spi_pkg::OP_YSAVE: begin
        if (cmd_i.side) qz_q <= neg_q[1] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
        else            qw_q <= qmag;
      end
      spi_pkg::OP_EMIT_INIT: begin
        for (int c = 0; c < 3; c++) begin
          qo_q[c] <= '0;
          rr_q[c] <= {2'b00, n_q};
        end
        i_q <= '0;
      end
      spi_pkg::OP_EMIT_STEP: begin
        for (int c = 0; c < 3; c++) begin
          rr_q[c] <= ecor[c] ? 8'(esum[c] - n2) : esum[c];
          qo_q[c] <= qo_q[c] + sr_q[c] + 33'(ecor[c]);
        end
        i_q <= i_q + 6'd1;
      end
      default: ;
    endcase
  end

  // sample positions
  logic [33:0] pos [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pos[c] = neg_q[c] ? 34'({{2{s_q[c][31]}}, s_q[c]} - {1'b0, qo_q[c]})
                        : 34'({{2{s_q[c][31]}}, s_q[c]} + {1'b0, qo_q[c]});
    end
  end

  assign out_o.pos_x   = pos[0][31:0];
  assign out_o.pos_y   = pos[1][31:0];
  assign out_o.pos_z   = pos[2][31:0];
  assign out_o.quat_z  = qz_q;
  assign out_o.quat_w  = qw_q;
  assign out_o.clipped = clip_q;
  assign out_o.last    = i_q == n_q;

  assign status_o.search_done = search_done;
  assign status_o.xy_zero     = (m_q[0] == 33'd0) && (m_q[1] == 33'd0);
  assign status_o.last        = i_q == n_q;
  assign include_start_o      = inc_q;

endmodule

// File: src/segment_path_interpolator_core.sv
// From input beat to first sample offered the segment passes the squares, the bit-serial
// square root (34 steps, used four times, or twice when the segment has no xy extent),
// the count search and the serial divisions; a clear include_start adds the skip step.
// After that one sample beat per cycle while out_ready_i.
// One segment is in flight at a time; in_ready_o rises the cycle after the last beat.
// Reset (asynchronous, active low): controller idle, spacing back to 0.25 m.
// Top level; uses spi_pkg, spi_ctrl, spi_dp and the assertion macro header.
`include "segment_path_interpolator_core_assert.svh"
module segment_path_interpolator_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  spi_pkg::seg_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output spi_pkg::pose_t out_o
);

  spi_pkg::cmd_t    cmd;
  spi_pkg::status_t status;
  logic             include_start;

  spi_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .include_start_i (include_start),
    .in_ready_o      (in_ready_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  spi_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_i            (in_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .include_start_o (include_start),
    .out_o           (out_o)
  );

  // assertions
  `SPI_ASSERT_ALWAYS(a_no_overlap, !(in_ready_o && out_valid_o), "input and output both open")
  `SPI_ASSERT(a_busy_after_in, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after input beat")
  `SPI_ASSERT(a_idle_after_last, (out_valid_o && out_ready_i && out_o.last) |=> in_ready_o, "not idle after last beat")

endmodule

// File: sim/tb_segment_path_interpolator_core.sv
// Testbench for segment_path_interpolator_core: random and directed segments, self-checking
// against a predictor of the sampled poses. Depends on spi_pkg and the core RTL only.
module tb_segment_path_interpolator_core;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           cfg_we_i = 1'b0;
  logic [31:0]    cfg_wdata_i = '0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  spi_pkg::seg_t  in_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  spi_pkg::pose_t out_o;

  spi_pkg::pose_t pose_q[$];
  logic [31:0]    spacing_cfg = spi_pkg::SPACING_RESET;
  int             err_cnt = 0;
  int             hold_cycles = 0;
  int             stall_left = 0;
  bit             quiet = 1'b0;

  segment_path_interpolator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #60_000_000;
    $display("tb_segment_path_interpolator_core NOT OK");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // floor square root of a sum of squares
  function automatic logic [63:0] sqrt_floor(input logic [127:0] s);
    logic [63:0] res, cand;
    res = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (128'(cand) * 128'(cand) <= s) res = cand;
    end
    return res;
  endfunction

  // nearest square root, ties up
  function automatic logic [63:0] sqrt_near(input logic [63:0] v);
    logic [63:0] res, cand;
    res = '0;
    for (int b = 15; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (cand * cand <= v) res = cand;
    end
    if (v - res * res > res) res++;
    return res;
  endfunction

  function automatic logic [31:0] sample_pos(input longint s, input longint d,
                                             input logic [63:0] m, input logic [63:0] i,
                                             input logic [63:0] n);
    logic [63:0] q;
    q = (2 * i * m + n) / (2 * n);
    return (d < 0) ? 32'(s - longint'(q)) : 32'(s + longint'(q));
  endfunction

  // works out every pose of one segment and queues them
  function automatic void predict_poses(input spi_pkg::seg_t seg);
    longint         sv[3], dv[3];
    logic [63:0]    mg[3];
    logic [127:0]   len_sq, xy_sq, t;
    logic [63:0]    n, r, rp, rm, qw, zm, first;
    logic [15:0]    qz;
    bit             clip;
    spi_pkg::pose_t p;
    sv[0] = seg.start_x; sv[1] = seg.start_y; sv[2] = seg.start_z;
    dv[0] = longint'(seg.end_x) - sv[0];
    dv[1] = longint'(seg.end_y) - sv[1];
    dv[2] = longint'(seg.end_z) - sv[2];
    for (int c = 0; c < 3; c++) mg[c] = (dv[c] < 0) ? 64'(-dv[c]) : 64'(dv[c]);
    xy_sq  = 128'(mg[0]) * 128'(mg[0]) + 128'(mg[1]) * 128'(mg[1]);
    len_sq = xy_sq + 128'(mg[2]) * 128'(mg[2]);
    n = '0;
    for (int k = 1; k <= spi_pkg::SAMPLE_MAX_INT; k++) begin
      t = 128'(k) * 128'(spacing_cfg);
      if (n == 0 && t * t >= len_sq) n = 64'(k);
    end
    clip = (n == 0);
    if (clip) n = 64'(spi_pkg::SAMPLE_MAX_INT);
    qz = '0;
    qw = 64'(spi_pkg::QUAT_ONE);
    if (dv[0] != 0 || dv[1] != 0) begin
      r  = sqrt_floor(xy_sq);
      rp = 64'(longint'(r) + dv[0]);
      rm = 64'(longint'(r) - dv[0]);
      qw = sqrt_near((rp << 27) / r);
      zm = sqrt_near((rm << 27) / r);
      if (qw > 64'd16384) qw = 64'd16384;
      if (zm > 64'd16384) zm = 64'd16384;
      qz = (dv[1] < 0) ? -zm[15:0] : zm[15:0];
    end
    first = seg.include_start ? 64'd0 : 64'd1;
    for (logic [63:0] i = first; i <= n; i++) begin
      p.pos_x   = sample_pos(sv[0], dv[0], mg[0], i, n);
      p.pos_y   = sample_pos(sv[1], dv[1], mg[1], i, n);
      p.pos_z   = sample_pos(sv[2], dv[2], mg[2], i, n);
      p.quat_z  = qz;
      p.quat_w  = qw[14:0];
      p.clipped = clip;
      p.last    = (i == n);
      pose_q    = {pose_q, p};
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  // receiver: random stalls plus a requested long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // result checker
  always @(posedge clk_i) begin
    spi_pkg::pose_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pose_q.size() == 0) begin
        report_mismatch("unexpected pose beat", 1, 0);
      end else begin
        w = pose_q.pop_front();
        if (out_o.pos_x !== w.pos_x) report_mismatch("pos_x", out_o.pos_x, w.pos_x);
        if (out_o.pos_y !== w.pos_y) report_mismatch("pos_y", out_o.pos_y, w.pos_y);
        if (out_o.pos_z !== w.pos_z) report_mismatch("pos_z", out_o.pos_z, w.pos_z);
        if (out_o.quat_z !== w.quat_z) report_mismatch("quat_z", out_o.quat_z, w.quat_z);
        if (out_o.quat_w !== w.quat_w) report_mismatch("quat_w", out_o.quat_w, w.quat_w);
        if (out_o.clipped !== w.clipped) report_mismatch("clipped", out_o.clipped, w.clipped);
        if (out_o.last !== w.last) report_mismatch("last", out_o.last, w.last);
      end
    end
  end

  // one segment beat; valid stays up on return so back-to-back beats need no dip
  task automatic send_seg(input spi_pkg::seg_t seg);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= seg;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_poses(seg);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_spacing(input logic [31:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    spacing_cfg = v;
  endtask

  function automatic spi_pkg::seg_t make_seg(input logic [31:0] sx, input logic [31:0] sy,
                                             input logic [31:0] sz, input logic [31:0] ex,
                                             input logic [31:0] ey, input logic [31:0] ez,
                                             input bit inc);
    spi_pkg::seg_t s;
    s = '{sx, sy, sz, ex, ey, ez, inc};
    return s;
  endfunction

  // end point a bounded random step from start, kept inside the 32 bit range
  function automatic logic [31:0] step_from(input logic [31:0] st, input longint span);
    longint d, e;
    d = longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF) % (span + 1);
    if (d > 64'sh7FFF_FFFF) d = 64'sh7FFF_FFFF;
    if ($urandom_range(0, 1)) d = -d;
    e = longint'($signed(st)) + d;
    if (e > 64'sh7FFF_FFFF || e < -64'sh8000_0000) e = longint'($signed(st)) - d;
    return 32'(e);
  endfunction

  function automatic spi_pkg::seg_t rand_seg();
    spi_pkg::seg_t s;
    longint        span;
    s.start_x = $urandom; s.start_y = $urandom; s.start_z = $urandom;
    s.include_start = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 4) == 0) begin
      s.end_x = $urandom; s.end_y = $urandom; s.end_z = $urandom;
    end else begin
      // length around a few spacings so the count spreads over its range
      span = longint'(spacing_cfg) * $urandom_range(0, 80) / 2;
      s.end_x = step_from(s.start_x, span);
      s.end_y = ($urandom_range(0, 7) == 0) ? s.start_y : step_from(s.start_y, span);
      s.end_z = step_from(s.start_z, span);
    end
    return s;
  endfunction

  task automatic test_directed();
    send_seg(make_seg(0, 0, 0, 0, 0, 0, 0));                 // zero length
    send_seg(make_seg(5, 6, 7, 5, 6, 7, 1));
    send_seg(make_seg(0, 0, 0, 0, 0, 32'h0001_0000, 1));      // no xy direction
    send_seg(make_seg(0, 0, 0, 32'hFFFF_0000, 0, 0, 1));      // yaw of pi
    send_seg(make_seg(0, 0, 0, 32'h0001_0000, 0, 0, 0));
    send_seg(make_seg(0, 0, 0, 0, 32'h0000_8000, 0, 0));
    send_seg(make_seg(0, 0, 0, 0, 32'hFFFF_8000, 0, 1));
    send_seg(make_seg(0, 0, 0, 32'hFFFF_C000, 32'hFFFF_D000, 0, 0));
    send_seg(make_seg(0, 0, 0, 32'h0000_4000, 0, 0, 0));      // exactly one spacing
    send_seg(make_seg(0, 0, 0, 32'h0000_4001, 0, 0, 0));
    send_seg(make_seg(0, 0, 0, 32'h000F_C000, 0, 0, 1));      // exactly the maximum count
    send_seg(make_seg(0, 0, 0, 32'h000F_C001, 0, 0, 1));      // one over: clipped
    send_seg(make_seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
    send_seg(make_seg(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
    send_seg(make_seg(32'h7FFF_FFFF, 32'h8000_0000, 0,
                      32'h8000_0000, 32'h7FFF_FFFF, 0, 1));
    send_seg(make_seg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0));
    send_seg(make_seg(3, 0, 0, 0, 1, 0, 1));
  endtask

  task automatic test_random(input int cnt);
    repeat (cnt) send_seg(rand_seg());
  endtask

  // receiver stops for a long stretch while segments keep coming
  task automatic test_backpressure();
    drain();
    hold_cycles = 600;
    repeat (5) send_seg(rand_seg());
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed();
    test_random(60);
    write_spacing(32'h0000_0001);
    test_random(25);
    write_spacing(32'hFFFF_FFFF);
    test_directed();
    test_random(25);
    write_spacing(32'h0001_0000);
    test_random(60);
    test_backpressure();
    write_spacing($urandom_range(1, 32'h0008_0000));
    quiet = 1'b1;
    test_random(40);
    quiet = 1'b0;
    write_spacing($urandom);
    test_random(30);
    write_spacing(32'h0000_0100);
    test_random(70);
    drain();
    repeat (300) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_segment_path_interpolator_core OK");
    end else begin
      $display("tb_segment_path_interpolator_core NOT OK");
    end
    $finish;
  end

endmodule
